FILE: rtl/core/ird_pkg.sv
package ird_pkg;

    // Default sizes of the ring.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Widest index and count that any legal capacity needs (capacity up to 256).
    localparam int IDX_MAX_W = 8;
    localparam int CNT_MAX_W = 9;

    // Operation codes carried in the operation field.
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_ROTATE = 3'd4;

    // Error codes returned with every result.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_PUT    = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_ROTATE = 3'd4;

    // One chain command: what to do, at which index, with the current fill.
    typedef struct packed {
        logic [2:0]           kind;
        logic [IDX_MAX_W-1:0] index;
        logic [CNT_MAX_W-1:0] count;
    } chain_cmd_t;

endpackage

FILE: rtl/core/ird_cell.sv
module ird_cell #(
    parameter int DATA_WIDTH = ird_pkg::DATA_WIDTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                   aclk,
    input  ird_pkg::chain_cmd_t    cmd,
    input  logic [DATA_WIDTH-1:0]  new_word,
    input  logic [DATA_WIDTH-1:0]  lower_q,
    input  logic [DATA_WIDTH-1:0]  upper_q,
    input  logic [DATA_WIDTH-1:0]  wrap_q,
    output logic [DATA_WIDTH-1:0]  q
);

    localparam logic [ird_pkg::CNT_MAX_W-1:0] ME      = ird_pkg::CNT_MAX_W'(CELL_IDX);
    localparam logic [ird_pkg::CNT_MAX_W-1:0] ME_NEXT = ird_pkg::CNT_MAX_W'(CELL_IDX + 1);

    logic [DATA_WIDTH-1:0]            word_reg;
    logic [DATA_WIDTH-1:0]            word_next;
    logic [ird_pkg::CNT_MAX_W-1:0]    idx;

    assign idx = ird_pkg::CNT_MAX_W'(cmd.index);

    // Each cell decides from its own place whether it loads, shifts or holds.
    always_comb begin
        word_next = word_reg;
        case (cmd.kind)
            ird_pkg::CMD_PUT: begin
                if (ME == idx) begin
                    word_next = new_word;
                end
            end
            ird_pkg::CMD_INSERT: begin
                if (ME == idx) begin
                    word_next = new_word;
                end else if (ME > idx && ME <= cmd.count) begin
                    word_next = lower_q;
                end
            end
            ird_pkg::CMD_REMOVE: begin
                if (ME >= idx && ME_NEXT < cmd.count) begin
                    word_next = upper_q;
                end
            end
            ird_pkg::CMD_ROTATE: begin
                // One place toward the front; the front word wraps to the back.
                if (ME_NEXT < cmd.count) begin
                    word_next = upper_q;
                end else if (ME_NEXT == cmd.count) begin
                    word_next = wrap_q;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

FILE: rtl/core/ird_ctrl.sv
module ird_ctrl #(
    parameter int CAPACITY   = ird_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ird_pkg::DATA_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic signed [5:0]           position,
    input  logic [31:0]                 value,
    input  logic [DATA_WIDTH-1:0]       cell_q [CAPACITY],
    output ird_pkg::chain_cmd_t         cmd,
    output logic [DATA_WIDTH-1:0]       new_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 old_value,
    output logic [4:0]                  length,
    output logic [1:0]                  error
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CW + 2 > 7) ? CW + 2 : 7;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_ROTATE = 1'b1;

    localparam logic signed [SW-1:0] S_ZERO = SW'(0);
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic [CW-1:0]        C_ONE  = CW'(1);
    localparam logic [CW-1:0]        C_CAP  = CW'(CAPACITY);

    logic                    state_reg;
    logic                    state_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CW-1:0]           rot_left_reg;
    logic [CW-1:0]           rot_left_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [31:0]             old_reg;
    logic [31:0]             old_next;
    logic [1:0]              err_reg;
    logic [1:0]              err_next;
    logic [4:0]              len_reg;

    logic                    accept;
    logic signed [SW-1:0]    pos_s;
    logic signed [SW-1:0]    n_s;
    logic signed [SW-1:0]    mag_s;
    logic signed [SW-1:0]    at_s;
    logic signed [SW-1:0]    steps_s;
    logic [DATA_WIDTH-1:0]   rd_word;
    logic [2:0]              dec_kind;
    logic [IW-1:0]           dec_idx;
    logic [CW-1:0]           dec_steps;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign new_word = DATA_WIDTH'(value);

    // Signed views of the position and the fill for the range checks.
    assign pos_s   = {{(SW - 6){position[5]}}, position};
    assign n_s     = $signed({{(SW - CW){1'b0}}, count_reg});
    assign mag_s   = (pos_s < S_ZERO) ? -pos_s : pos_s;
    assign at_s    = (pos_s > S_ZERO) ? pos_s - S_ONE : pos_s + n_s;
    assign steps_s = (pos_s > S_ZERO) ? n_s - pos_s : mag_s;
    assign rd_word = cell_q[pos_s[IW-1:0]];

    // Decode of the item at the input: checks, result and chain command.
    always_comb begin
        err_next   = ird_pkg::ERR_OK;
        old_next   = '0;
        count_next = count_reg;
        dec_kind   = ird_pkg::CMD_HOLD;
        dec_idx    = '0;
        dec_steps  = '0;
        case (operation)
            ird_pkg::OP_GET, ird_pkg::OP_PUT, ird_pkg::OP_REMOVE: begin
                if (pos_s < S_ZERO || pos_s >= n_s) begin
                    err_next = ird_pkg::ERR_RANGE;
                end else begin
                    old_next = 32'(rd_word);
                    dec_idx  = pos_s[IW-1:0];
                    if (operation == ird_pkg::OP_PUT) begin
                        dec_kind = ird_pkg::CMD_PUT;
                    end else if (operation == ird_pkg::OP_REMOVE) begin
                        dec_kind   = ird_pkg::CMD_REMOVE;
                        count_next = count_reg - C_ONE;
                    end
                end
            end
            ird_pkg::OP_ADD: begin
                if (pos_s < -n_s || pos_s > n_s + S_ONE) begin
                    err_next = ird_pkg::ERR_RANGE;
                end else if (count_reg == C_CAP) begin
                    err_next = ird_pkg::ERR_FULL;
                end else begin
                    old_next   = 32'(new_word);
                    dec_kind   = ird_pkg::CMD_INSERT;
                    dec_idx    = at_s[IW-1:0];
                    count_next = count_reg + C_ONE;
                end
            end
            ird_pkg::OP_ROTATE: begin
                if (mag_s > n_s) begin
                    err_next = ird_pkg::ERR_RANGE;
                end else if (mag_s != S_ZERO && mag_s != n_s) begin
                    dec_steps = steps_s[CW-1:0];
                end
            end
            default: begin
                err_next = ird_pkg::ERR_RANGE;
            end
        endcase
    end

    // Command to the cells: rotate steps while busy, else the accepted item.
    always_comb begin
        cmd.kind  = ird_pkg::CMD_HOLD;
        cmd.index = ird_pkg::IDX_MAX_W'(dec_idx);
        cmd.count = ird_pkg::CNT_MAX_W'(count_reg);
        if (state_reg == ST_ROTATE) begin
            cmd.kind = ird_pkg::CMD_ROTATE;
        end else if (accept) begin
            cmd.kind = dec_kind;
        end
    end

    // Sequencer for the single-place rotate steps.
    always_comb begin
        state_next    = state_reg;
        rot_left_next = rot_left_reg;
        if (state_reg == ST_ROTATE) begin
            rot_left_next = rot_left_reg - C_ONE;
            if (rot_left_reg == C_ONE) begin
                state_next = ST_IDLE;
            end
        end else if (accept && dec_steps != '0) begin
            state_next    = ST_ROTATE;
            rot_left_next = dec_steps;
        end
    end

    // The result word is held until the output side takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rot_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rot_left_reg  <= rot_left_next;
            out_valid_reg <= out_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            old_reg   <= old_next;
            err_reg   <= err_next;
            len_reg   <= 5'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign old_value = old_reg;
    assign error     = err_reg;
    assign length    = len_reg;

endmodule

FILE: rtl/core/indexed_ring_deque_unit.sv
// Ring of up to CAPACITY words held in logical order in a chain of cells, one word per
// cell, index 0 in the first cell. Each input word carries an operation (get, put, add at
// a signed position, remove, rotate by a signed count) and yields one result word with the
// old or added word, the fill after the operation and an error code; a flagged item leaves
// the ring unchanged. Get, put, add, remove and every flagged item are done in the cycle
// they are accepted, with any change to the chain and the result registered together, so
// a new word can be accepted every cycle while the output side takes each result and no
// rotate is under way. A rotate by a count k with 0 < |k| < n is accepted like any other
// word, then turns the ring one place per cycle by a shift along the chain, n - k places for
// k > 0 and |k| for k < 0 (at most CAPACITY - 1), taking no input; other k shift nothing.
module indexed_ring_deque_unit #(
    parameter int CAPACITY   = ird_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ird_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [8:3] position, [40:9] value, [47:41] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] old_value, [36:32] length, [38:37] error, [39] zero
    output logic [39:0] m_tdata
);

    logic [DATA_WIDTH-1:0]  cell_q [CAPACITY];
    logic [DATA_WIDTH-1:0]  new_word;
    ird_pkg::chain_cmd_t    cmd;
    logic [31:0]            old_value;
    logic [4:0]             length;
    logic [1:0]             error;

    // Sequencer, range checks and result register.
    ird_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tdata[2:0]),
        .position  (s_tdata[8:3]),
        .value     (s_tdata[40:9]),
        .cell_q    (cell_q),
        .cmd       (cmd),
        .new_word  (new_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .old_value (old_value),
        .length    (length),
        .error     (error)
    );

    // The chain of cells; the ends take zeros from their missing neighbors.
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic [DATA_WIDTH-1:0] lower_q;
        logic [DATA_WIDTH-1:0] upper_q;

        if (j == 0) begin : g_first
            assign lower_q = '0;
        end else begin : g_inner_lo
            assign lower_q = cell_q[j-1];
        end

        if (j == CAPACITY - 1) begin : g_last
            assign upper_q = '0;
        end else begin : g_inner_hi
            assign upper_q = cell_q[j+1];
        end

        ird_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (j)
        ) u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .new_word (new_word),
            .lower_q  (lower_q),
            .upper_q  (upper_q),
            .wrap_q   (cell_q[0]),
            .q        (cell_q[j])
        );
    end

    assign m_tdata = {1'b0, error, length, old_value};

endmodule
